/* sv/mscgl_pkg.sv */
// Package for the multi-stop color gradient: widths, key layout, reset values and the
// divider word that travels down the pipeline. Depends on nothing.
package mscgl_pkg;

  localparam int POS_W     = 16;
  localparam int CHAN_W    = 8;
  localparam int CHAN_N    = 4;
  localparam int KEY_SLOTS = 8;
  localparam int NUM_KEYS  = 8;
  localparam int KEY_IDX_W = $clog2(KEY_SLOTS);
  localparam int CFG_IDX_W = 4;
  localparam int KEY_W     = POS_W + CHAN_N * CHAN_W;

  localparam int FRAC_BITS = 15;
  localparam int FAC_W     = FRAC_BITS + 1;

  // Restoring division: DIV_STEP quotient bits per stage.
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (FAC_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_T      = DIV_STAGES * DIV_STEP;

  localparam int PROD_W = CHAN_W + FAC_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic [POS_W-1:0] ONE_POS = POS_W'(1 << FRAC_BITS);
  localparam logic [FAC_W-1:0] ONE_FAC = FAC_W'(1 << FRAC_BITS);
  localparam logic [SUM_W-1:0] HALF    = SUM_W'(1 << (FRAC_BITS - 1));

  // Channel lanes inside a key, matching the register packing.
  localparam int CH_RED   = 3;
  localparam int CH_GREEN = 2;
  localparam int CH_BLUE  = 1;
  localparam int CH_ALPHA = 0;

  typedef logic [KEY_IDX_W-1:0] key_idx_t;

  typedef struct packed {
    logic [POS_W-1:0]             pos;
    logic [CHAN_N-1:0][CHAN_W-1:0] chan;
  } key_t;

  typedef key_t [KEY_SLOTS-1:0] keys_t;

  localparam key_t KEY0_RESET = '{pos: '0, chan: '1};
  localparam key_t KEY_RESET  = '{pos: ONE_POS, chan: '1};

  typedef struct packed {
    key_idx_t         lo_idx;
    key_idx_t         up_idx;
    logic             direct;
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] rem;
    logic [DIV_T-1:0] num;
    logic [DIV_T-1:0] quo;
  } div_msg_t;

  typedef logic [CHAN_N-1:0][PROD_W-1:0] prod_vec_t;

endpackage

/* sv/mscgl_locate.sv */
// Key search and span setup: two pipeline stages that find the bracketing keys and
// prepare the dividend and divisor. Depends on mscgl_pkg.
module mscgl_locate (
  input  logic                clk,
  input  logic                rst,
  input  mscgl_pkg::keys_t    keys,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         position,
  output logic                out_valid,
  input  logic                out_stall,
  output mscgl_pkg::div_msg_t out_msg
);
  import mscgl_pkg::*;

  logic             v1;
  logic             hold1;
  logic             hold2;
  logic [POS_W-1:0] p_clamp;
  key_idx_t         up_next;
  logic             found_next;
  logic [POS_W-1:0] p1;
  key_idx_t         up1;
  logic             found1;

  key_idx_t                 lo_sel;
  key_idx_t                 hi_sel;
  logic                     direct_sel;
  logic [POS_W-1:0]         gap;
  logic [POS_W+DIV_T-1:0]   ext;
  div_msg_t                 msg_next;

  assign hold2    = out_valid && out_stall;
  assign hold1    = v1 && hold2;
  assign in_stall = hold1;

  // Stage one: clamp and find the first key at or above the position.
  always_comb begin
    p_clamp    = (position > ONE_POS) ? ONE_POS : position;
    up_next    = '0;
    found_next = 1'b0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (p_clamp <= keys[i].pos) begin
        up_next    = KEY_IDX_W'(i);
        found_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!hold1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !hold1) begin
      p1     <= p_clamp;
      up1    <= up_next;
      found1 <= found_next;
    end
  end

  // Stage two: pick the lower and upper keys, form distance and span.
  always_comb begin
    direct_sel = !found1 || (up1 == '0);
    if (!found1) begin
      lo_sel = KEY_IDX_W'(NUM_KEYS - 1);
      hi_sel = KEY_IDX_W'(NUM_KEYS - 1);
    end else if (up1 == '0) begin
      lo_sel = '0;
      hi_sel = '0;
    end else begin
      lo_sel = up1 - 1'b1;
      hi_sel = up1;
    end
    gap = p1 - keys[lo_sel].pos;
    ext = (POS_W + DIV_T)'({gap, {FRAC_BITS{1'b0}}});
    msg_next.lo_idx = lo_sel;
    msg_next.up_idx = hi_sel;
    msg_next.direct = direct_sel;
    msg_next.span   = keys[hi_sel].pos - keys[lo_sel].pos;
    msg_next.rem    = ext[POS_W+DIV_T-1:DIV_T];
    msg_next.num    = ext[DIV_T-1:0];
    msg_next.quo    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && !hold2) begin
      out_msg <= msg_next;
    end
  end

endmodule

/* sv/mscgl_div_stage.sv */
// One stage of the pipelined restoring divider: DIV_STEP quotient bits per stage.
// Depends on mscgl_pkg.
module mscgl_div_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mscgl_pkg::div_msg_t in_msg,
  output logic                out_valid,
  input  logic                out_stall,
  output mscgl_pkg::div_msg_t out_msg
);
  import mscgl_pkg::*;

  logic             hold;
  logic [POS_W:0]   r2;
  logic [POS_W:0]   diff;
  logic             ge;
  div_msg_t         m;

  assign hold     = out_valid && out_stall;
  assign in_stall = hold;

  always_comb begin
    m    = in_msg;
    r2   = '0;
    diff = '0;
    ge   = 1'b0;
    for (int s = 0; s < DIV_STEP; s++) begin
      r2   = {m.rem, m.num[DIV_T-1]};
      diff = r2 - {1'b0, m.span};
      ge   = (r2 >= {1'b0, m.span});
      m.rem = ge ? diff[POS_W-1:0] : r2[POS_W-1:0];
      m.num = m.num << 1;
      m.quo = {m.quo[DIV_T-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !hold) begin
      out_msg <= m;
    end
  end

endmodule

/* sv/mscgl_blend.sv */
// Channel blend: products in one stage, rounded sums into the output register in the next.
// Depends on mscgl_pkg.
module mscgl_blend (
  input  logic                clk,
  input  logic                rst,
  input  mscgl_pkg::keys_t    keys,
  input  logic                in_valid,
  output logic                in_stall,
  input  mscgl_pkg::div_msg_t in_msg,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic [7:0]          alpha
);
  import mscgl_pkg::*;

  logic             va;
  logic             hold_a;
  logic             hold_b;
  logic [FAC_W-1:0] factor;
  logic [FAC_W-1:0] inv;
  key_t             lo_key;
  key_t             hi_key;
  prod_vec_t        prod_lo_next;
  prod_vec_t        prod_hi_next;
  prod_vec_t        prod_lo;
  prod_vec_t        prod_hi;
  logic [CHAN_N-1:0][CHAN_W-1:0] chan_next;
  logic [SUM_W-1:0] sum;

  assign hold_b   = out_valid && out_stall;
  assign hold_a   = va && hold_b;
  assign in_stall = hold_a;

  // At or below the first key, or past the last one, the upper key's color comes out whole.
  always_comb begin
    factor = in_msg.direct ? ONE_FAC : in_msg.quo[FAC_W-1:0];
    inv    = ONE_FAC - factor;
    lo_key = keys[in_msg.lo_idx];
    hi_key = keys[in_msg.up_idx];
    for (int c = 0; c < CHAN_N; c++) begin
      prod_lo_next[c] = PROD_W'(lo_key.chan[c]) * PROD_W'(inv);
      prod_hi_next[c] = PROD_W'(hi_key.chan[c]) * PROD_W'(factor);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (!hold_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !hold_a) begin
      prod_lo <= prod_lo_next;
      prod_hi <= prod_hi_next;
    end
  end

  // The weights sum to one, so the rounded result always fits in a channel.
  always_comb begin
    sum = '0;
    for (int c = 0; c < CHAN_N; c++) begin
      sum          = SUM_W'(prod_lo[c]) + SUM_W'(prod_hi[c]) + HALF;
      chan_next[c] = sum[FRAC_BITS+CHAN_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold_b) begin
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (va && !hold_b) begin
      red   <= chan_next[CH_RED];
      green <= chan_next[CH_GREEN];
      blue  <= chan_next[CH_BLUE];
      alpha <= chan_next[CH_ALPHA];
    end
  end

endmodule

/* sv/multi_stop_color_gradient_lerp.sv */
// Multi-stop linear color gradient: top level with the key registers and the pipeline.
// Depends on mscgl_pkg, mscgl_locate, mscgl_div_stage and mscgl_blend.
//
// The block turns a Q1.15 gradient position into an RGBA8 color. It accepts one word per
// clock while position_stall is low, and it returns exactly one color word for each
// accepted word, in order. The eight stages are: key search, span setup, four
// stages of a restoring divider that produce four bits of the Q1.15 blend factor each,
// the channel products, and the rounded sums in the output register. Positions above 1.0
// are treated as 1.0. The block takes the first key whose position is at or above the
// input and blends from the key before it; at or below key 0 it returns key 0's color,
// and if no key lies at or above the input it returns the last key's color. Keys are
// written through the configuration port, which is always ready; write them only while
// no word is in flight. Software keeps the keys sorted, key 0 at 0.0 and the last used
// key at 1.0; writes to an index beyond the key list are dropped. A stall on the output
// holds the pipeline from the back, and the input keeps accepting words as long as
// some stage ahead of it is empty.
module multi_stop_color_gradient_lerp (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        position_valid,
  output logic        position_stall,
  input  logic [15:0] position,
  output logic        color_valid,
  input  logic        color_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha
);
  import mscgl_pkg::*;

  keys_t    keys;
  div_msg_t div_msg   [DIV_STAGES+1];
  logic     div_valid [DIV_STAGES+1];
  logic     div_stall [DIV_STAGES+1];

  // Configuration is taken every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys[0] <= KEY0_RESET;
      for (int k = 1; k < KEY_SLOTS; k++) begin
        keys[k] <= KEY_RESET;
      end
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(KEY_SLOTS))) begin
      keys[cfg_index[KEY_IDX_W-1:0]] <= key_t'(cfg_data);
    end
  end

  mscgl_locate u_locate (
    .clk       (clk),
    .rst       (rst),
    .keys      (keys),
    .in_valid  (position_valid),
    .in_stall  (position_stall),
    .position  (position),
    .out_valid (div_valid[0]),
    .out_stall (div_stall[0]),
    .out_msg   (div_msg[0])
  );

  // The divider stages are chained; each one hands its word to the next.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    mscgl_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_valid[g]),
      .in_stall  (div_stall[g]),
      .in_msg    (div_msg[g]),
      .out_valid (div_valid[g+1]),
      .out_stall (div_stall[g+1]),
      .out_msg   (div_msg[g+1])
    );
  end

  mscgl_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .keys      (keys),
    .in_valid  (div_valid[DIV_STAGES]),
    .in_stall  (div_stall[DIV_STAGES]),
    .in_msg    (div_msg[DIV_STAGES]),
    .out_valid (color_valid),
    .out_stall (color_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha)
  );

endmodule

/* bench/tb_multi_stop_color_gradient_lerp.sv */
// Self-checking testbench for the multi-stop color gradient: directed and random positions
// checked against a local predictor of the key search and channel blend.
// Depends on mscgl_pkg and multi_stop_color_gradient_lerp.
module tb_multi_stop_color_gradient_lerp;
  import mscgl_pkg::*;

  // One blended color as the block returns it.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  // What the checker waits for: the color, plus the position that caused it for messages.
  typedef struct packed {
    logic [POS_W-1:0] position;
    rgba_t            color;
  } expected_color_t;

  // Shapes of the random key sets.
  typedef enum int {
    GRAD_SORTED,     // key 0 at 0.0, last used key at 1.0, trailing keys repeat it
    GRAD_CLUSTERED,  // tiny spans near 0.0 and colors at the channel extremes
    GRAD_SHORT,      // sorted, but key 0 and the last key keep random positions
    GRAD_UNSORTED    // arbitrary 16-bit key positions in any order
  } gradient_style_t;

  localparam int RUN_LIMIT       = 4_000_000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int PHASES          = 12;
  localparam int WORDS_PER_PHASE = 62;
  localparam int MAX_CFG_INDEX   = (1 << CFG_IDX_W) - 1;

  logic                 clk            = 1'b0;
  logic                 rst            = 1'b1;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [KEY_W-1:0]     cfg_data       = '0;
  logic                 position_valid = 1'b0;
  logic                 position_stall;
  logic [POS_W-1:0]     position       = '0;
  logic                 color_valid;
  logic                 color_stall    = 1'b0;
  logic [CHAN_W-1:0]    red;
  logic [CHAN_W-1:0]    green;
  logic [CHAN_W-1:0]    blue;
  logic [CHAN_W-1:0]    alpha;

  // The predictor's copy of the key registers, and the set about to be loaded.
  key_t gradient_keys [KEY_SLOTS];
  key_t next_keys     [KEY_SLOTS];

  expected_color_t expected_colors [$];
  int              mismatches = 0;
  bit              idling_on  = 1'b1;
  int              stall_left = 0;

  multi_stop_color_gradient_lerp dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .position_valid (position_valid),
    .position_stall (position_stall),
    .position       (position),
    .color_valid    (color_valid),
    .color_stall    (color_stall),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .alpha          (alpha)
  );

  always #5 clk = ~clk;

  // A hung handshake or a lost word ends the run here.
  initial begin
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Predicts the color for one position from the current keys. The position is
  // saturated to 1.0, then the first key at or above it becomes the upper key. When
  // that is key 0, or when no key qualifies, the color of key 0 or of the last key
  // comes out unblended. Otherwise the lower key lies strictly below the position,
  // so the span is never zero.
  function automatic rgba_t blend_color(logic [POS_W-1:0] pos_in);
    logic [POS_W-1:0]              p;
    int                            upper;
    int                            lower;
    int                            i;
    longint unsigned               factor;
    longint unsigned               offset;
    longint unsigned               span;
    longint unsigned               mix;
    logic [CHAN_N-1:0][CHAN_W-1:0] lerped;
    rgba_t                         c;
    p = (pos_in > ONE_POS) ? ONE_POS : pos_in;
    upper = -1;
    for (i = 0; i < NUM_KEYS; i++) begin
      if (upper < 0 && p <= gradient_keys[i].pos) upper = i;
    end
    if (upper <= 0) begin
      lower = (upper == 0) ? 0 : NUM_KEYS - 1;
      upper = lower;
      factor = ONE_FAC;
    end else begin
      lower = upper - 1;
      offset = p - gradient_keys[lower].pos;
      span = gradient_keys[upper].pos - gradient_keys[lower].pos;
      factor = (offset << FRAC_BITS) / span;
      if (factor > ONE_FAC) factor = ONE_FAC;
    end
    // Each channel is a rounded fixed-point blend of the two keys.
    for (i = 0; i < CHAN_N; i++) begin
      mix = gradient_keys[lower].chan[i] * (ONE_FAC - factor)
            + gradient_keys[upper].chan[i] * factor + HALF;
      mix = mix >> FRAC_BITS;
      lerped[i] = (mix > 255) ? 8'hFF : mix[7:0];
    end
    c.red   = lerped[CH_RED];
    c.green = lerped[CH_GREEN];
    c.blue  = lerped[CH_BLUE];
    c.alpha = lerped[CH_ALPHA];
    return c;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  task automatic check_channel(string name, logic [POS_W-1:0] pos,
                               logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
    if (got !== want)
      report_mismatch($sformatf("%s for position %04h: expected %02h, got %02h",
                                name, pos, want, got));
  endtask

  // Every color word taken from the block is compared with the oldest expectation.
  always @(posedge clk) begin : check_colors
    expected_color_t entry;
    if (!rst && color_valid === 1'b1 && color_stall === 1'b0) begin
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("color %02h %02h %02h %02h came with no position waiting",
                                  red, green, blue, alpha));
      end else begin
        entry = expected_colors.pop_front();
        check_channel("red", entry.position, entry.color.red, red);
        check_channel("green", entry.position, entry.color.green, green);
        check_channel("blue", entry.position, entry.color.blue, blue);
        check_channel("alpha", entry.position, entry.color.alpha, alpha);
      end
    end
  end

  // The output side stalls in bursts of random length while idling is on. During a burst,
  // stall_left counts down while color_stall is held high.
  always @(posedge clk) begin
    if (rst) begin
      color_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      color_stall <= 1'b1;
      stall_left <= $urandom_range(1, 4);
    end else begin
      color_stall <= 1'b0;
      stall_left <= 0;
    end
  end

  // Sends one position word, with a random gap ahead of it while idling is on. The task
  // is entered and left at a rising edge, and valid stays high after acceptance so that
  // back-to-back words need no second assignment in the same step.
  task automatic send_position(input logic [POS_W-1:0] p);
    expected_color_t entry;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      position_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    position_valid <= 1'b1;
    position <= p;
    do @(posedge clk); while (position_stall !== 1'b0);
    entry.position = p;
    entry.color = blend_color(p);
    expected_colors = {expected_colors, entry};
  endtask

  // Stops the input and waits until every color in flight has come back, so the keys
  // may be rewritten. Each word gives exactly one color, so an empty queue means idle.
  task automatic wait_for_drain();
    position_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
  endtask

  // Writes one register; indexes past the key list are dropped by the block and here.
  task automatic write_key_reg(input int idx, input logic [KEY_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx < KEY_SLOTS) gradient_keys[idx] = data;
  endtask

  task automatic finish_key_writes();
    cfg_valid <= 1'b0;
  endtask

  task automatic load_gradient();
    int k;
    for (k = 0; k < KEY_SLOTS; k++) write_key_reg(k, next_keys[k]);
  endtask

  task automatic reset_key_model();
    int k;
    gradient_keys[0] = KEY0_RESET;
    for (k = 1; k < KEY_SLOTS; k++) gradient_keys[k] = KEY_RESET;
  endtask

  // Builds a random key set of the given shape into next_keys.
  task automatic make_random_gradient(gradient_style_t style);
    logic [POS_W-1:0] stops [KEY_SLOTS];
    logic [POS_W-1:0] swap;
    int               used;
    int               i;
    int               j;
    int               ch;
    used = (style == GRAD_UNSORTED) ? KEY_SLOTS : $urandom_range(2, KEY_SLOTS);
    for (i = 0; i < KEY_SLOTS; i++) begin
      case (style)
        GRAD_CLUSTERED: stops[i] = POS_W'($urandom_range(1, 12));
        GRAD_UNSORTED:  stops[i] = POS_W'($urandom_range(0, 16'hFFFF));
        default:        stops[i] = POS_W'($urandom_range(0, ONE_POS));
      endcase
      if (style == GRAD_CLUSTERED) begin
        for (ch = 0; ch < CHAN_N; ch++)
          next_keys[i].chan[ch] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        next_keys[i].chan = $urandom;
      end
    end
    if (style != GRAD_UNSORTED) begin
      for (i = 0; i < used; i++) begin
        for (j = 0; j + 1 < used - i; j++) begin
          if (stops[j] > stops[j+1]) begin
            swap = stops[j];
            stops[j] = stops[j+1];
            stops[j+1] = swap;
          end
        end
      end
      // Well-formed sets span exactly 0.0 to 1.0; short ones keep their random ends.
      if (style != GRAD_SHORT) begin
        stops[0] = '0;
        stops[used-1] = ONE_POS;
      end
    end
    for (i = 0; i < used; i++) next_keys[i].pos = stops[i];
    for (i = used; i < KEY_SLOTS; i++) next_keys[i] = next_keys[used-1];
  endtask

  // Mostly positions inside 0.0..1.0, with a good share right at and beside the keys,
  // at the two ends, and over the whole 16-bit range to hit saturation.
  function automatic logic [POS_W-1:0] random_position();
    int               roll;
    int               k;
    logic [POS_W-1:0] near;
    roll = $urandom_range(0, 99);
    if (roll < 55) return POS_W'($urandom_range(0, ONE_POS));
    if (roll < 70) begin
      k = $urandom_range(0, KEY_SLOTS - 1);
      near = gradient_keys[k].pos + POS_W'($urandom_range(0, 2)) - 16'd1;
      return near;
    end
    if (roll < 80) return $urandom_range(0, 1) ? ONE_POS : '0;
    return POS_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Out of reset every key is opaque white, so any position gives white.
  task automatic test_reset_gradient();
    send_position('0);
    send_position(ONE_POS);
    send_position(16'hFFFF);
  endtask

  // A sorted set with one-step and wide spans, extreme colors and both ends of the
  // position range, saturation included.
  task automatic test_sorted_gradient();
    wait_for_drain();
    next_keys[0] = {16'h0000, 32'h0000_0000};
    next_keys[1] = {16'h1000, 32'hFF00_80FF};
    next_keys[2] = {16'h2000, 32'h80FF_00C0};
    next_keys[3] = {16'h2001, 32'h00FF_FF01};
    next_keys[4] = {16'h4000, 32'hFFFF_FFFF};
    next_keys[5] = {16'h6000, 32'h1234_5678};
    next_keys[6] = {16'h7FFF, 32'hFE01_7F80};
    next_keys[7] = {16'h8000, 32'hFFFF_FFFF};
    load_gradient();
    finish_key_writes();
    send_position(16'h0000);
    send_position(16'h0800);
    send_position(16'h1000);
    send_position(16'h2001);
    send_position(16'h3000);
    send_position(16'h7FFF);
    send_position(16'h8000);
    send_position(16'hFFFF);
  endtask

  // Unsorted keys with key 0 above 0.0 and every key below 1.0: positions under key 0,
  // a lower key that sits out of order, and positions past every key, saturated or not.
  task automatic test_unsorted_and_short_keys();
    wait_for_drain();
    next_keys[0] = {16'h1000, 32'hFF00_0000};
    next_keys[1] = {16'h0800, 32'h00FF_0000};
    next_keys[2] = {16'h3000, 32'h0000_FF00};
    next_keys[3] = {16'h2000, 32'h0000_00FF};
    next_keys[4] = {16'h5000, 32'h8080_8080};
    next_keys[5] = {16'h4000, 32'h4020_1008};
    next_keys[6] = {16'h5800, 32'hA5A5_5A5A};
    next_keys[7] = {16'h6000, 32'h0102_0304};
    load_gradient();
    finish_key_writes();
    send_position(16'h0000);
    send_position(16'h1000);
    send_position(16'h1800);
    send_position(16'h2800);
    send_position(16'h7000);
    send_position(16'h9000);
  endtask

  // Writes to indexes past the key list must leave the keys as they were.
  task automatic test_ignored_indexes();
    int idx;
    wait_for_drain();
    for (idx = KEY_SLOTS; idx <= MAX_CFG_INDEX; idx++)
      write_key_reg(idx, (idx % 2 == 0) ? '1 : {16'h0000, 32'h0000_0000});
    finish_key_writes();
    send_position(16'h4000);
    send_position(16'h8000);
    send_position(16'hFFFF);
  endtask

  // Random key sets, each followed by a run of random positions. The last phases run
  // without any idling so that the block is also seen at full rate.
  task automatic test_random_gradients();
    int              phase;
    int              n;
    int              roll;
    gradient_style_t style;
    for (phase = 0; phase < PHASES; phase++) begin
      roll = $urandom_range(0, 99);
      if (phase == 0)      style = GRAD_CLUSTERED;
      else if (roll < 55)  style = GRAD_SORTED;
      else if (roll < 70)  style = GRAD_CLUSTERED;
      else if (roll < 85)  style = GRAD_SHORT;
      else                 style = GRAD_UNSORTED;
      if (phase >= PHASES - 2) idling_on = 1'b0;
      wait_for_drain();
      make_random_gradient(style);
      load_gradient();
      if ($urandom_range(0, 2) == 0)
        write_key_reg($urandom_range(KEY_SLOTS, MAX_CFG_INDEX), KEY_W'({$urandom, $urandom}));
      finish_key_writes();
      for (n = 0; n < WORDS_PER_PHASE; n++) send_position(random_position());
    end
  endtask

  // Reset once, run the tests in turn, then drain and give the verdict.
  initial begin
    reset_key_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_gradient();
    test_sorted_gradient();
    test_unsorted_and_short_keys();
    test_ignored_indexes();
    test_random_gradients();
    wait_for_drain();
    // A further wait catches any color word that should not exist.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
